// ===== src/cc3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the 3D circumcenter block.
// No dependencies; used by the center channel interface, the top level and the checker.
package cc3_pkg;

    // Result coordinates are signed 32-bit fixed point.
    localparam int OUT_W = 32;

    // Quotient bits produced by the divider: one more than the output, so that
    // the negative limit can be told apart from an overflow.
    localparam int QB = OUT_W + 1;

    localparam logic [QB-1:0]    Q_POS_MAX = 33'h0_7FFF_FFFF;
    localparam logic [QB-1:0]    Q_NEG_MAX = 33'h0_8000_0000;
    localparam logic [OUT_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG   = 32'h8000_0000;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic signed [OUT_W-1:0] center_z;
        logic                    degenerate;
        logic                    saturated;
    } t_result;

endpackage

// ===== src/cc3_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the 3D circumcenter block: point triples in,
// centers out. Depends on cc3_pkg for the result width.
interface cc3_pts_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;
    logic signed [COORD_WIDTH-1:0] p3_x;
    logic signed [COORD_WIDTH-1:0] p3_y;
    logic signed [COORD_WIDTH-1:0] p3_z;

    modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                    input ready);
    modport sink   (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                    output ready);
endinterface

interface cc3_ctr_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cc3_pkg::OUT_W-1:0]     center_x;
    logic signed [cc3_pkg::OUT_W-1:0]     center_y;
    logic signed [cc3_pkg::OUT_W-1:0]     center_z;
    logic                                 degenerate;
    logic                                 saturated;

    modport source (output valid, center_x, center_y, center_z, degenerate, saturated,
                    input ready);
    modport sink   (input valid, center_x, center_y, center_z, degenerate, saturated,
                    output ready);
endinterface

// ===== src/circumcenter_3d.sv =====
`timescale 1ns / 1ps
// Circumcenter of three 3D points, exact integer Cramer solution, deep pipeline.
// Depends on cc3_pkg and on the channel interfaces in cc3_if.sv.
//
// Usage:
//   i_pts carries one point triple per transaction, o_ctr one center with its
//   degenerate and saturated flags. The datapath is a chain of 46 register
//   stages: eleven arithmetic stages (differences, cross product, squared
//   norms, numerators), a range check, one stage per quotient bit of a
//   restoring divider (33 stages for each of the three coordinates, run side
//   by side), and the output register.
//   Throughput: one triple per cycle while the skid register is empty, set by
//   the one-bit-per-stage divider, which takes a new dividend in every cycle
//   in which the chain is not held.
//   A skid register behind the output register takes the result when the
//   receiver stalls; i_pts.ready drops only while that register is full, and
//   the whole chain then holds in place, valid bits and data together.
//   Reset (synchronous, active low) clears all valid bits and the valid flag
//   of the skid register; no result is pending afterwards.
module circumcenter_3d #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    cc3_pts_if.sink   i_pts,
    cc3_ctr_if.source o_ctr
);

    localparam int QB    = cc3_pkg::QB;
    localparam int OW    = cc3_pkg::OUT_W;
    localparam int CW    = COORD_WIDTH;
    localparam int UW    = CW + 1;
    localparam int PW    = 2 * CW + 2;
    localparam int NW    = 2 * CW + 3;
    localparam int NH    = (NW + 1) / 2;
    localparam int NHW   = NW - NH;
    localparam int NLPW  = NW + NH + 1;
    localparam int NHPW  = NW + NHW;
    localparam int SQW   = 2 * NW;
    localparam int DW    = 4 * CW + 5;
    localparam int WW    = 3 * CW + 4;
    localparam int WL    = (WW + 1) / 2;
    localparam int WHW   = WW - WL;
    localparam int PHW   = WHW + NW;
    localparam int PLW   = WL + 1 + NW;
    localparam int TW    = 5 * CW + 6;
    localparam int DL    = (DW + 2) / 3;
    localparam int DTW   = DW - 2 * DL;
    localparam int PDW   = CW + DL + 1;
    localparam int NUMW  = 5 * CW + 7;
    localparam int MW    = NUMW - 1 + FRAC_BITS;
    localparam int MHW   = MW - QB;
    localparam int CMPW  = (MHW > DW) ? MHW : DW;

    localparam int ST_DIV0 = 11;
    localparam int ST_OUT  = ST_DIV0 + QB + 1;
    localparam int NS      = ST_OUT + 1;

    logic [NS-1:0] r_v;
    logic          r_skid_v;
    logic          en;

    cc3_pkg::t_result r_out;
    cc3_pkg::t_result r_skid;
    cc3_pkg::t_result n_out;

    // Stage A..G
    logic signed [CW-1:0]   r_p   [9];
    logic signed [CW-1:0]   r_p1s [3][6];
    logic signed [UW-1:0]   r_uB  [3];
    logic signed [UW-1:0]   r_vB  [3];
    logic signed [UW-1:0]   r_uC  [3];
    logic signed [UW-1:0]   r_vC  [3];
    logic signed [PW-1:0]   r_m   [6];
    logic signed [PW-1:0]   r_su  [3];
    logic signed [PW-1:0]   r_sv  [3];
    logic signed [NW-1:0]   r_nD  [3];
    logic signed [NW-1:0]   r_nE  [3];
    logic signed [NW-1:0]   r_nF  [3];
    logic signed [UW-1:0]   r_uD  [3];
    logic signed [UW-1:0]   r_vD  [3];
    logic signed [NW-1:0]   r_uuD;
    logic signed [NW-1:0]   r_vvD;
    logic signed [NLPW-1:0] r_nlp [3];
    logic signed [NHPW-1:0] r_nhp [3];
    logic signed [WW-1:0]   r_uvE [3];
    logic signed [WW-1:0]   r_vuE [3];
    logic signed [SQW-1:0]  r_sqF [3];
    logic signed [WW-1:0]   r_wF  [3];
    logic [DW-1:0]          r_denG;
    logic signed [PHW-1:0]  r_phG [3][2];
    logic signed [PLW-1:0]  r_plG [3][2];
    logic signed [SQW+1:0]  n_sum;

    // Stage H..K
    logic [DW-1:0]          r_denH, r_denI, r_denJ, r_denK;
    logic                   r_degH, r_degI, r_degJ, r_degK;
    logic signed [TW-1:0]   r_tH  [3];
    logic signed [TW-1:0]   r_tI  [3];
    logic signed [PDW-1:0]  r_pdH [3][3];
    logic signed [NUMW-1:0] r_pdI [3];
    logic signed [NUMW-1:0] r_numJ[3];
    logic                   r_negK[3];
    logic [MW-1:0]          r_magK[3];

    // Divider
    logic [DW-1:0]          r_dden [QB+1];
    logic                   r_ddeg [QB+1];
    logic [DW-1:0]          r_rem  [3][QB+1];
    logic [QB-1:0]          r_low  [3][QB+1];
    logic [QB-1:0]          r_quo  [3][QB+1];
    logic                   r_dneg [3][QB+1];
    logic                   r_dbig [3][QB+1];

    logic [OW-1:0]          n_val  [3];
    logic                   n_sat  [3];

    assign en          = !r_skid_v;
    assign i_pts.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_pts.valid};
        end
    end

    // Input capture, cross product, squared norms and the shared denominator path.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= i_pts.p1_x;
            r_p[1] <= i_pts.p1_y;
            r_p[2] <= i_pts.p1_z;
            r_p[3] <= i_pts.p2_x;
            r_p[4] <= i_pts.p2_y;
            r_p[5] <= i_pts.p2_z;
            r_p[6] <= i_pts.p3_x;
            r_p[7] <= i_pts.p3_y;
            r_p[8] <= i_pts.p3_z;
            // Cross product n = u x v from the six partial products.
            r_nD[0] <= NW'(r_m[0]) - NW'(r_m[1]);
            r_nD[1] <= NW'(r_m[2]) - NW'(r_m[3]);
            r_nD[2] <= NW'(r_m[4]) - NW'(r_m[5]);
            r_uuD   <= NW'(r_su[0]) + NW'(r_su[1]) + NW'(r_su[2]);
            r_vvD   <= NW'(r_sv[0]) + NW'(r_sv[1]) + NW'(r_sv[2]);
            r_denG  <= {n_sum[DW-2:0], 1'b0};
            r_denH  <= r_denG;
            r_degH  <= (r_denG == '0);
            r_denI  <= r_denH;
            r_degI  <= r_degH;
            r_denJ  <= r_denI;
            r_degJ  <= r_degI;
            r_denK  <= r_denJ;
            r_degK  <= r_degJ;
            r_dden[0] <= r_denK;
            r_ddeg[0] <= r_degK;
        end
    end

    always_comb begin
        n_sum = (SQW+2)'(r_sqF[0]) + (SQW+2)'(r_sqF[1]) + (SQW+2)'(r_sqF[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m[0] <= PW'(r_uB[1]) * PW'(r_vB[2]);
            r_m[1] <= PW'(r_uB[2]) * PW'(r_vB[1]);
            r_m[2] <= PW'(r_uB[2]) * PW'(r_vB[0]);
            r_m[3] <= PW'(r_uB[0]) * PW'(r_vB[2]);
            r_m[4] <= PW'(r_uB[0]) * PW'(r_vB[1]);
            r_m[5] <= PW'(r_uB[1]) * PW'(r_vB[0]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int A = (k + 1) % 3;
        localparam int B = (k + 2) % 3;

        logic signed [WHW-1:0]  wh_a, wh_b;
        logic signed [WL:0]     wl_a, wl_b;
        logic signed [PHW:0]    dh;
        logic signed [PLW:0]    dl;
        logic signed [DL:0]     limb [3];
        logic [MW-1:0]          mag_n;
        logic signed [NUMW-1:0] abs_n;

        assign wh_a = $signed(r_wF[A][WW-1:WL]);
        assign wh_b = $signed(r_wF[B][WW-1:WL]);
        assign wl_a = $signed({1'b0, r_wF[A][WL-1:0]});
        assign wl_b = $signed({1'b0, r_wF[B][WL-1:0]});
        assign dh   = (PHW+1)'(r_phG[k][0]) - (PHW+1)'(r_phG[k][1]);
        assign dl   = (PLW+1)'(r_plG[k][0]) - (PLW+1)'(r_plG[k][1]);
        assign limb[0] = $signed({1'b0, r_denG[DL-1:0]});
        assign limb[1] = $signed({1'b0, r_denG[2*DL-1:DL]});
        assign limb[2] = $signed({{(DL-DTW+1){1'b0}}, r_denG[DW-1:2*DL]});
        assign abs_n   = r_numJ[k][NUMW-1] ? -r_numJ[k] : r_numJ[k];
        assign mag_n   = MW'(abs_n[NUMW-2:0]) << FRAC_BITS;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_uB[k]   <= UW'(r_p[3+k]) - UW'(r_p[k]);
                r_vB[k]   <= UW'(r_p[6+k]) - UW'(r_p[k]);
                r_p1s[k][0] <= r_p[k];
                for (int s = 1; s < 6; s++) r_p1s[k][s] <= r_p1s[k][s-1];
                r_uC[k]   <= r_uB[k];
                r_vC[k]   <= r_vB[k];
                r_su[k]   <= PW'(r_uB[k]) * PW'(r_uB[k]);
                r_sv[k]   <= PW'(r_vB[k]) * PW'(r_vB[k]);
                r_uD[k]   <= r_uC[k];
                r_vD[k]   <= r_vC[k];
                // Square of n in two halves of one operand.
                r_nlp[k]  <= NLPW'(r_nD[k]) * NLPW'($signed({1'b0, r_nD[k][NH-1:0]}));
                r_nhp[k]  <= NHPW'(r_nD[k]) * NHPW'($signed(r_nD[k][NW-1:NH]));
                r_uvE[k]  <= WW'(r_uuD) * WW'(r_vD[k]);
                r_vuE[k]  <= WW'(r_vvD) * WW'(r_uD[k]);
                r_nE[k]   <= r_nD[k];
                r_sqF[k]  <= (SQW'(r_nhp[k]) <<< NH) + SQW'(r_nlp[k]);
                r_wF[k]   <= r_uvE[k] - r_vuE[k];
                r_nF[k]   <= r_nE[k];
                // Cross product w x n, w split into a high and a low half.
                r_phG[k][0] <= PHW'(wh_a) * PHW'(r_nF[B]);
                r_phG[k][1] <= PHW'(wh_b) * PHW'(r_nF[A]);
                r_plG[k][0] <= PLW'(wl_a) * PLW'(r_nF[B]);
                r_plG[k][1] <= PLW'(wl_b) * PLW'(r_nF[A]);
                r_tH[k]   <= (TW'(dh) <<< WL) + TW'(dl);
                for (int j = 0; j < 3; j++) begin
                    r_pdH[k][j] <= PDW'(r_p1s[k][5]) * PDW'(limb[j]);
                end
                r_pdI[k]  <= (NUMW'(r_pdH[k][2]) <<< (2 * DL))
                           + (NUMW'(r_pdH[k][1]) <<< DL) + NUMW'(r_pdH[k][0]);
                r_tI[k]   <= r_tH[k];
                r_numJ[k] <= r_pdI[k] + NUMW'(r_tI[k]);
                r_negK[k] <= r_numJ[k][NUMW-1];
                r_magK[k] <= mag_n;
                // Range check: a quotient of 2^33 or more saturates anyway.
                r_dbig[k][0] <= CMPW'(r_magK[k][MW-1:QB]) >= CMPW'(r_denK);
                r_rem[k][0]  <= DW'(r_magK[k][MW-1:QB]);
                r_low[k][0]  <= r_magK[k][QB-1:0];
                r_quo[k][0]  <= '0;
                r_dneg[k][0] <= r_negK[k];
            end
        end

        for (genvar d = 1; d <= QB; d++) begin : g_div
            logic [DW:0] rem2;
            logic        ge;

            assign rem2 = {r_rem[k][d-1], r_low[k][d-1][QB-1]};
            assign ge   = rem2 >= {1'b0, r_dden[d-1]};

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[k][d]  <= ge ? DW'(rem2 - {1'b0, r_dden[d-1]}) : rem2[DW-1:0];
                    r_low[k][d]  <= r_low[k][d-1] << 1;
                    r_quo[k][d]  <= {r_quo[k][d-1][QB-2:0], ge};
                    r_dneg[k][d] <= r_dneg[k][d-1];
                    r_dbig[k][d] <= r_dbig[k][d-1];
                end
            end
        end

        always_comb begin
            if (!r_dneg[k][QB]) begin
                n_sat[k] = r_dbig[k][QB] || (r_quo[k][QB] > cc3_pkg::Q_POS_MAX);
                n_val[k] = n_sat[k] ? cc3_pkg::SAT_POS : r_quo[k][QB][OW-1:0];
            end else begin
                n_sat[k] = r_dbig[k][QB] || (r_quo[k][QB] > cc3_pkg::Q_NEG_MAX);
                n_val[k] = n_sat[k] ? cc3_pkg::SAT_NEG : OW'(0) - r_quo[k][QB][OW-1:0];
            end
        end
    end

    for (genvar d = 1; d <= QB; d++) begin : g_den
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dden[d] <= r_dden[d-1];
                r_ddeg[d] <= r_ddeg[d-1];
            end
        end
    end

    always_comb begin
        if (r_ddeg[QB]) begin
            n_out = '0;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.center_x   = n_val[0];
            n_out.center_y   = n_val[1];
            n_out.center_z   = n_val[2];
            n_out.degenerate = 1'b0;
            n_out.saturated  = n_sat[0] | n_sat[1] | n_sat[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
        if (!r_skid_v) begin
            r_skid <= r_out;
        end
    end

    // The skid register takes the output when it is not taken this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_ctr.ready) r_skid_v <= 1'b0;
        end else if (r_v[ST_OUT] && !o_ctr.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    assign o_ctr.valid      = r_skid_v | r_v[ST_OUT];
    assign o_ctr.center_x   = r_skid_v ? r_skid.center_x   : r_out.center_x;
    assign o_ctr.center_y   = r_skid_v ? r_skid.center_y   : r_out.center_y;
    assign o_ctr.center_z   = r_skid_v ? r_skid.center_z   : r_out.center_z;
    assign o_ctr.degenerate = r_skid_v ? r_skid.degenerate : r_out.degenerate;
    assign o_ctr.saturated  = r_skid_v ? r_skid.saturated  : r_out.saturated;

endmodule

// ===== src/cc3_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for circumcenter_3d, attached by the bind at the end.
// Depends on cc3_pkg for the result width and saturation codes.
module cc3_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [cc3_pkg::OUT_W-1:0]     i_center_x,
    input logic [cc3_pkg::OUT_W-1:0]     i_center_y,
    input logic [cc3_pkg::OUT_W-1:0]     i_center_z,
    input logic                          i_degenerate,
    input logic                          i_saturated
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_center_x, i_center_y, i_center_z, i_degenerate, i_saturated}))
        else $error("stalled result changed");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_center_x == '0 && i_center_y == '0
            && i_center_z == '0 && !i_saturated)
        else $error("degenerate result is not zero");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |->
            i_center_x == cc3_pkg::SAT_POS || i_center_x == cc3_pkg::SAT_NEG ||
            i_center_y == cc3_pkg::SAT_POS || i_center_y == cc3_pkg::SAT_NEG ||
            i_center_z == cc3_pkg::SAT_POS || i_center_z == cc3_pkg::SAT_NEG)
        else $error("saturated flag without a clipped coordinate");

    // With no result pending the skid register is empty, so input is taken.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no pending result");

endmodule

bind circumcenter_3d cc3_chk u_cc3_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pts.ready),
    .i_out_valid  (o_ctr.valid),
    .i_out_ready  (o_ctr.ready),
    .i_center_x   (o_ctr.center_x),
    .i_center_y   (o_ctr.center_y),
    .i_center_z   (o_ctr.center_z),
    .i_degenerate (o_ctr.degenerate),
    .i_saturated  (o_ctr.saturated)
);
